/* rtl/four_axis_pid_antiwindup_assert.svh */
// Assertion macros for the four-axis PID controller
`ifndef FOUR_AXIS_PID_ANTIWINDUP_ASSERT_SVH
`define FOUR_AXIS_PID_ANTIWINDUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FAPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fapa check failed");
`define FAPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fapa check failed");
`else
`define FAPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FAPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/fapa_pkg.sv */
// Shared types, widths, register codes and helpers for the PID controller
`default_nettype none
package fapa_pkg;

  localparam int NUM_AXES  = 4;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int AWG_W     = 8;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int PROD_W    = ERR_W + GAIN_W + 1;
  localparam int PD_W      = PROD_W + 1;
  localparam int RAW_W     = PD_W + FRAC_W + 1;
  localparam int DIFF_W    = RAW_W + 1;
  localparam int SAT_IN_W  = DIFF_W + AWG_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

  localparam logic [63:0] PROP_RST   = 64'd900723310005257310;
  localparam logic [63:0] DERIV_RST  = 64'd1688852106563355520;
  localparam logic [63:0] INTEG_RST  = 64'd0;
  localparam logic [31:0] WINDUP_RST = 32'd252514060;
  localparam logic [63:0] LIMIT_RST  = 64'd56295210093772950;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic clamp;
    logic fin;
  } fapa_ctrl_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-ACC_W:0] top;
    top = v[SAT_IN_W-1:ACC_W-1];
    if (top == '0 || top == '1) begin
      sat_acc = v[ACC_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/four_axis_pid_antiwindup.sv */
// Top level: four-axis PID controller with back-calculation anti-windup.
// Results show on the out_ ports once the five-step lane sequence (load, multiply,
// integrate, clamp, anti-windup) has run; in_stall holds off a new item until then,
// and a stalled output holds the last step.
// Reset: synchronous active-low; gains and limits return to defaults,
// integrators and anti-windup terms clear to zero.
`default_nettype none
`include "four_axis_pid_antiwindup_assert.svh"
module four_axis_pid_antiwindup (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_we,
  input  wire logic [fapa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [fapa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                        in_valid,
  output logic                                       in_stall,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_alt_target,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_alt_measured,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_alt_rate,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_roll_target,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_roll_measured,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_roll_rate,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_pitch_target,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_pitch_measured,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_pitch_rate,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_yaw_target,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_yaw_measured,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0]  in_yaw_rate,
  output logic                                       out_valid,
  input  wire                                        out_stall,
  output logic signed [fapa_pkg::SAMPLE_W-1:0]       out_alt_drive,
  output logic signed [fapa_pkg::SAMPLE_W-1:0]       out_roll_drive,
  output logic signed [fapa_pkg::SAMPLE_W-1:0]       out_pitch_drive,
  output logic signed [fapa_pkg::SAMPLE_W-1:0]       out_yaw_drive
);
  import fapa_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_MUL   = 3'd1;
  localparam logic [2:0] PH_ACC   = 3'd2;
  localparam logic [2:0] PH_CLAMP = 3'd3;
  localparam logic [2:0] PH_AW    = 3'd4;

  logic [63:0] prop_r, deriv_r, integ_r, limit_r;
  logic [31:0] windup_r;
  logic [2:0]  phase_r, phase_nxt;
  logic        out_valid_r;
  logic        accept, out_free;
  fapa_ctrl_t  ctrl;

  logic signed [SAMPLE_W-1:0] tgt  [NUM_AXES];
  logic signed [SAMPLE_W-1:0] meas [NUM_AXES];
  logic signed [SAMPLE_W-1:0] rate [NUM_AXES];
  logic signed [SAMPLE_W-1:0] drv  [NUM_AXES];
  logic signed [SAMPLE_W-1:0] drive_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r   <= PROP_RST;
      deriv_r  <= DERIV_RST;
      integ_r  <= INTEG_RST;
      windup_r <= WINDUP_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP:   prop_r   <= cfg_data;
        REG_DERIV:  deriv_r  <= cfg_data;
        REG_INTEG:  integ_r  <= cfg_data;
        REG_WINDUP: windup_r <= cfg_data[31:0];
        REG_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tgt[0]  = in_alt_target;   meas[0] = in_alt_measured;   rate[0] = in_alt_rate;
    tgt[1]  = in_roll_target;  meas[1] = in_roll_measured;  rate[1] = in_roll_rate;
    tgt[2]  = in_pitch_target; meas[2] = in_pitch_measured; rate[2] = in_pitch_rate;
    tgt[3]  = in_yaw_target;   meas[3] = in_yaw_measured;   rate[3] = in_yaw_rate;
  end

  assign in_stall = (phase_r != PH_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ctrl.load  = accept;
    ctrl.mul   = (phase_r == PH_MUL);
    ctrl.acc   = (phase_r == PH_ACC);
    ctrl.clamp = (phase_r == PH_CLAMP);
    ctrl.fin   = (phase_r == PH_AW) && out_free;
    case (phase_r)
      PH_IDLE:  phase_nxt = accept ? PH_MUL : PH_IDLE;
      PH_MUL:   phase_nxt = PH_ACC;
      PH_ACC:   phase_nxt = PH_CLAMP;
      PH_CLAMP: phase_nxt = PH_AW;
      PH_AW:    phase_nxt = out_free ? PH_IDLE : PH_AW;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (ctrl.fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    fapa_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .tgt   (tgt[a]),
      .meas  (meas[a]),
      .rate  (rate[a]),
      .kp    (prop_r[a*GAIN_W +: GAIN_W]),
      .kd    (deriv_r[a*GAIN_W +: GAIN_W]),
      .ki    (integ_r[a*GAIN_W +: GAIN_W]),
      .kaw   (windup_r[a*AWG_W +: AWG_W]),
      .lim   (limit_r[a*GAIN_W +: GAIN_W]),
      .drive (drv[a])
    );

    always_ff @(posedge clk) begin
      if (ctrl.fin) begin
        drive_r[a] <= drv[a];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alt_drive   = drive_r[0];
  assign out_roll_drive  = drive_r[1];
  assign out_pitch_drive = drive_r[2];
  assign out_yaw_drive   = drive_r[3];

  `FAPA_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, phase_r == PH_MUL)
  `FAPA_ASSERT_NXT(a_fin_delivers, clk, rst_n, ctrl.fin, out_valid_r && phase_r == PH_IDLE)
  `FAPA_ASSERT_NXT(a_blocked_holds, clk, rst_n, phase_r == PH_AW && !out_free, phase_r == PH_AW)

endmodule
`default_nettype wire

/* rtl/fapa_lane.sv */
// One axis lane: error, PID products, integrator, clamp and anti-windup term
`default_nettype none
module fapa_lane (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire fapa_pkg::fapa_ctrl_t             ctrl,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0] tgt,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0] meas,
  input  wire logic signed [fapa_pkg::SAMPLE_W-1:0] rate,
  input  wire logic [fapa_pkg::GAIN_W-1:0]     kp,
  input  wire logic [fapa_pkg::GAIN_W-1:0]     kd,
  input  wire logic [fapa_pkg::GAIN_W-1:0]     ki,
  input  wire logic [fapa_pkg::AWG_W-1:0]      kaw,
  input  wire logic [fapa_pkg::GAIN_W-1:0]     lim,
  output logic signed [fapa_pkg::SAMPLE_W-1:0] drive
);
  import fapa_pkg::*;

  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [SAMPLE_W-1:0] rate_r;
  logic signed [PROD_W-1:0]   pki_r, pki_nxt;
  logic signed [PROD_W-1:0]   pkp_r, pkp_nxt;
  logic signed [PROD_W-1:0]   pkd_r, pkd_nxt;
  logic signed [ACC_W-1:0]    integ_r, integ_nxt;
  logic signed [PD_W-1:0]     pd_r, pd_nxt;
  logic signed [RAW_W-1:0]    clamped_r, clamped_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [ACC_W-1:0]    windup_r, windup_nxt;
  logic signed [SAT_IN_W-1:0] acc_sum;
  logic signed [SAT_IN_W-1:0] aw_prod;
  logic signed [RAW_W-1:0]    raw;
  logic signed [RAW_W-1:0]    limq;
  logic [SAMPLE_W-2:0]        lim_eff;

  always_comb begin
    err_nxt = ERR_W'(tgt) - ERR_W'(meas);
    pki_nxt = PROD_W'(err_r) * PROD_W'($signed({1'b0, ki}));
    pkp_nxt = PROD_W'(err_r) * PROD_W'($signed({1'b0, kp}));
    pkd_nxt = PROD_W'(rate_r) * PROD_W'($signed({1'b0, kd}));

    acc_sum   = SAT_IN_W'(integ_r) + SAT_IN_W'(pki_r) + SAT_IN_W'(windup_r);
    integ_nxt = sat_acc(acc_sum);
    pd_nxt    = PD_W'(pkp_r) - PD_W'(pkd_r);

    lim_eff = lim[SAMPLE_W-1] ? '1 : lim[SAMPLE_W-2:0];
    limq    = RAW_W'($signed({1'b0, lim_eff, {FRAC_W{1'b0}}}));
    raw     = (RAW_W'(pd_r) <<< FRAC_W) + RAW_W'(integ_r);
    if (raw > limq) begin
      clamped_nxt = limq;
    end else if (raw < -limq) begin
      clamped_nxt = -limq;
    end else begin
      clamped_nxt = raw;
    end
    diff_nxt = DIFF_W'(clamped_nxt) - DIFF_W'(raw);

    aw_prod    = SAT_IN_W'(diff_r) * SAT_IN_W'($signed({1'b0, kaw}));
    windup_nxt = sat_acc(aw_prod);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_r  <= err_nxt;
      rate_r <= rate;
    end
    if (ctrl.mul) begin
      pki_r <= pki_nxt;
      pkp_r <= pkp_nxt;
      pkd_r <= pkd_nxt;
    end
    if (ctrl.acc) begin
      pd_r <= pd_nxt;
    end
    if (ctrl.clamp) begin
      clamped_r <= clamped_nxt;
      diff_r    <= diff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      windup_r <= '0;
    end else begin
      if (ctrl.acc) begin
        integ_r <= integ_nxt;
      end
      if (ctrl.fin) begin
        windup_r <= windup_nxt;
      end
    end
  end

  assign drive = clamped_r[FRAC_W +: SAMPLE_W];

endmodule
`default_nettype wire
